[rtl/gclt_pkg.sv]
// Package for the greedy centroid label tracker.
// Shared constants, payload words and controller/datapath command types.
// No dependencies.
package gclt_pkg;

	localparam int MAX_LABELS_DEF = 256;

	localparam logic [15:0] LABEL_MAX    = 16'hFFFF;
	localparam logic [15:0] ID_FIRST     = 16'd1;
	localparam logic [16:0] MAX_DIST_RST = 17'h1FFFF;

	localparam logic FUNC_LABEL  = 1'b0;
	localparam logic FUNC_COMMIT = 1'b1;

	typedef struct packed {
		logic        func;
		logic [15:0] center_x;
		logic [15:0] center_y;
	} in_t;

	typedef struct packed {
		logic [15:0] assigned_label;
		logic        is_new;
		logic [7:0]  matched_index;
		logic        table_full;
		logic        ids_exhausted;
	} out_t;

	typedef struct packed {
		logic load;
		logic commit;
		logic issue;
		logic mark;
		logic store;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic pipe_busy;
	} status_t;

endpackage

[rtl/greedy_centroid_label_tracker.sv]
// Top level of the greedy centroid label tracker: config register, controller
// and datapath. Depends on gclt_pkg, gclt_ctrl, gclt_dp.
//
//   channel  | handshake              | word
//   ---------+------------------------+-------------------------------
//   item     | start && !busy         | gclt_pkg::in_t
//   result   | done (one cycle)       | gclt_pkg::out_t
//   config   | psel&penable&pwrite    | max_dist at paddr 0
//
// For a label word, the previous-frame entries are read one per cycle from the
// entry memory, then pass square, sum and compare stages; entries already taken
// leave the pipe early. A commit word is taken while idle and raises neither
// busy nor done. busy stays high from accept to the store cycle. The result
// receiver cannot stall. Reset leaves the entry memory unset.
module greedy_centroid_label_tracker #(
	parameter int MAX_LABELS = gclt_pkg::MAX_LABELS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  gclt_pkg::in_t  item,
	output logic           done,
	output gclt_pkg::out_t result,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	logic [16:0]       max_dist_q;
	gclt_pkg::cmd_t    cmd;
	gclt_pkg::status_t status;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {15'd0, max_dist_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q <= gclt_pkg::MAX_DIST_RST;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			max_dist_q <= pwdata[16:0];
		end
	end

	gclt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (item.func),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gclt_dp #(
		.MAX_LABELS (MAX_LABELS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.item     (item),
		.max_dist (max_dist_q),
		.status   (status),
		.result   (result)
	);

endmodule

[rtl/gclt_ctrl.sv]
// Controller state machine of the label tracker.
// Sequences accept, scan, drain, mark and store; drives cmd_t, reads status_t.
// Depends on gclt_pkg.
module gclt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              func,
	input  gclt_pkg::status_t status,
	output gclt_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_MARK  = 5'b01000,
		ST_STORE = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.load   = accept && (func == gclt_pkg::FUNC_LABEL);
		cmd.commit = accept && (func == gclt_pkg::FUNC_COMMIT);
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_done) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = ST_MARK;
				end
			end
			ST_MARK: begin
				cmd.mark = 1'b1;
				state_d  = ST_STORE;
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_STORE);
		end
	end

endmodule

[rtl/gclt_dp.sv]
// Datapath of the label tracker: two-bank entry memory, taken-flag memory,
// scan pipeline (read, square, sum, compare), ID counter and result word.
// Depends on gclt_pkg.
module gclt_dp #(
	parameter int MAX_LABELS = gclt_pkg::MAX_LABELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gclt_pkg::cmd_t    cmd,
	input  gclt_pkg::in_t     item,
	input  logic [16:0]       max_dist,
	output gclt_pkg::status_t status,
	output gclt_pkg::out_t    result
);

	localparam int IW    = $clog2(MAX_LABELS);
	localparam int CW    = $clog2(MAX_LABELS + 1);
	localparam int DEPTH = 2 * MAX_LABELS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] BANK_OFS = AW'(MAX_LABELS);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_LABELS);

	typedef struct packed {
		logic [15:0] label;
		logic [15:0] y;
		logic [15:0] x;
	} entry_t;

	entry_t        ent_mem [DEPTH];
	logic          tk_mem  [DEPTH];

	logic          bank_q;
	logic [CW-1:0] prev_count_q;
	logic [CW-1:0] cur_count_q;
	logic [15:0]   next_id_q;
	logic [CW-1:0] scan_idx_q;
	logic [15:0]   cx_q;
	logic [15:0]   cy_q;
	logic [33:0]   limit_q;

	logic          v_s1, v_s2, v_s3;
	entry_t        ent_s1;
	logic          tk_s1;
	logic [IW-1:0] idx_s1, idx_s2, idx_s3;
	logic [31:0]   sqx_s2, sqy_s2;
	logic [15:0]   label_s2, label_s3;
	logic [32:0]   dist_s3;

	logic          found_q;
	logic [32:0]   best_d_q;
	logic [IW-1:0] best_i_q;
	logic [15:0]   best_label_q;

	logic [15:0]   label_q;
	logic          new_q;
	logic [7:0]    mi_q;
	gclt_pkg::out_t result_q;

	logic          in_range;
	logic          issue_ok;
	logic          room;
	logic [AW-1:0] prev_base;
	logic [AW-1:0] cur_base;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] mark_addr;
	logic [AW-1:0] cur_addr;
	logic          tk_we;
	logic [AW-1:0] tk_wa;
	logic [15:0]   adx, ady;
	logic          better;
	logic [IW+7:0] best_i_ext;

	assign in_range  = (scan_idx_q < prev_count_q);
	assign issue_ok  = cmd.issue && in_range;
	assign room      = (cur_count_q < FULL_CNT);
	assign prev_base = bank_q ? '0 : BANK_OFS;
	assign cur_base  = bank_q ? BANK_OFS : '0;
	assign rd_addr   = prev_base + AW'(scan_idx_q[IW-1:0]);
	assign mark_addr = prev_base + AW'(best_i_q);
	assign cur_addr  = cur_base + AW'(cur_count_q[IW-1:0]);
	assign tk_we     = (cmd.mark && found_q) || (cmd.store && room);
	assign tk_wa     = cmd.mark ? mark_addr : cur_addr;

	assign status.scan_done = !in_range;
	assign status.pipe_busy = v_s1 || v_s2 || v_s3;
	assign result           = result_q;

	assign adx = (ent_s1.x >= cx_q) ? (ent_s1.x - cx_q) : (cx_q - ent_s1.x);
	assign ady = (ent_s1.y >= cy_q) ? (ent_s1.y - cy_q) : (cy_q - ent_s1.y);

	assign better = v_s3 && ({1'b0, dist_s3} <= limit_q) && (!found_q || (dist_s3 < best_d_q));
	assign best_i_ext = {8'b0, best_i_q};

	// entry memory: one read port (scan), one write port (store)
	always_ff @(posedge clk) begin
		if (issue_ok) begin
			ent_s1 <= ent_mem[rd_addr];
			tk_s1  <= tk_mem[rd_addr];
		end
		if (cmd.store && room) begin
			ent_mem[cur_addr] <= '{label: label_q, y: cy_q, x: cx_q};
		end
		if (tk_we) begin
			tk_mem[tk_wa] <= cmd.mark;
		end
	end

	always_ff @(posedge clk) begin
		limit_q  <= 34'(max_dist) * 34'(max_dist);
		idx_s1   <= scan_idx_q[IW-1:0];
		sqx_s2   <= 32'(adx) * 32'(adx);
		sqy_s2   <= 32'(ady) * 32'(ady);
		label_s2 <= ent_s1.label;
		idx_s2   <= idx_s1;
		dist_s3  <= 33'(sqx_s2) + 33'(sqy_s2);
		label_s3 <= label_s2;
		idx_s3   <= idx_s2;
		if (cmd.load) begin
			cx_q <= item.center_x;
			cy_q <= item.center_y;
		end
		if (better) begin
			best_d_q     <= dist_s3;
			best_i_q     <= idx_s3;
			best_label_q <= label_s3;
		end
		if (cmd.mark) begin
			new_q   <= !found_q;
			label_q <= found_q ? best_label_q : next_id_q;
			mi_q    <= found_q ? best_i_ext[7:0] : 8'd0;
		end
		if (cmd.store) begin
			result_q.assigned_label <= label_q;
			result_q.is_new         <= new_q;
			result_q.matched_index  <= mi_q;
			result_q.table_full     <= !room;
			result_q.ids_exhausted  <= (next_id_q == gclt_pkg::LABEL_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q       <= 1'b0;
			prev_count_q <= '0;
			cur_count_q  <= '0;
			next_id_q    <= gclt_pkg::ID_FIRST;
			scan_idx_q   <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			v_s1 <= issue_ok;
			v_s2 <= v_s1 && !tk_s1;
			v_s3 <= v_s2;
			if (cmd.commit) begin
				bank_q       <= ~bank_q;
				prev_count_q <= cur_count_q;
				cur_count_q  <= '0;
			end
			if (cmd.load) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else begin
				if (issue_ok) begin
					scan_idx_q <= scan_idx_q + CW'(1);
				end
				if (better) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.mark && !found_q && (next_id_q != gclt_pkg::LABEL_MAX)) begin
				next_id_q <= next_id_q + 16'd1;
			end
			if (cmd.store && room) begin
				cur_count_q <= cur_count_q + CW'(1);
			end
		end
	end

endmodule
